### hdl/clm_pkg.sv
// types, codes and helpers shared by the locality monitor modules
package clm_pkg;

    localparam int OP_W      = 3;
    localparam int VAR_W     = 12;
    localparam int LABEL_W   = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 32;

    // event opcodes
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
    localparam logic [OP_W-1:0] OP_DECIDE = 3'd1;
    localparam logic [OP_W-1:0] OP_PROP   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COMMS = 2'd1;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VAR_W-1:0]   var_a;
        logic [VAR_W-1:0]   var_b;
        logic [LABEL_W-1:0] label;
    } evt_t;

    typedef struct packed {
        logic             ignored;
        logic [OUT_W-1:0] all_decisions;
        logic [OUT_W-1:0] same_decisions;
        logic [OUT_W-1:0] cross_decisions;
        logic [OUT_W-1:0] total_propagations;
        logic [OUT_W-1:0] same_propagations;
        logic [OUT_W-1:0] cross_propagations;
        logic [OUT_W-1:0] community_count;
    } res_t;

    // work classes decided by the front end
    typedef enum logic [2:0] {
        K_LOAD,
        K_DECIDE,
        K_PROP,
        K_CLEAR,
        K_READ,
        K_NOP,
        K_IGNORE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [VAR_W-1:0]   var_a;
        logic [VAR_W-1:0]   var_b;
        logic [LABEL_W-1:0] label;
    } cmd_t;

    // effective variable and community limits, already clamped to the maxima
    typedef struct packed {
        logic [CFG_W-1:0] nv;
        logic [CFG_W-1:0] nc;
    } limits_t;

    typedef struct packed {
        logic sweeping;
    } back_status_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_ISSUE,
        ST_LABEL_A,
        ST_LABEL_B,
        ST_HIST,
        ST_FINISH
    } back_state_t;

    function automatic logic in_range(input logic [VAR_W-1:0] v, input logic [CFG_W-1:0] lim);
        return {1'b0, v} < lim;
    endfunction

endpackage

### hdl/clm_ram.sv
// generic single write port ram with registered read
module clm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/clm_queue.sv
// two-entry command queue between front end and back end
module clm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  clm_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output clm_pkg::cmd_t head
);
    import clm_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

endmodule

### hdl/clm_front.sv
// front end: accepts event words and classifies them into back-end commands
module clm_front #(
    parameter int MAX_VARS = 4096
) (
    input  logic                  evt_valid,
    output logic                  evt_ready,
    input  clm_pkg::evt_t         evt,
    input  clm_pkg::limits_t      lim,
    input  clm_pkg::back_status_t status,
    input  logic                  q_full,
    output logic                  push,
    output clm_pkg::cmd_t         push_cmd
);
    import clm_pkg::*;

    localparam int MV_W = $clog2(MAX_VARS + 1);

    logic load_ok;

    // loads check against the table size, not against the variable count
    assign load_ok = {{MV_W{1'b0}}, evt.var_a} < {{VAR_W{1'b0}}, MV_W'(MAX_VARS)};

    assign evt_ready = !q_full && !status.sweeping;
    assign push      = evt_valid && evt_ready;

    always_comb
    begin
        push_cmd.var_a = evt.var_a;
        push_cmd.var_b = evt.var_b;
        push_cmd.label = evt.label;
        unique case (evt.op)
            OP_LOAD:
            begin
                push_cmd.kind = load_ok ? K_LOAD : K_IGNORE;
            end
            OP_DECIDE:
            begin
                push_cmd.kind = in_range(evt.var_a, lim.nv) ? K_DECIDE : K_IGNORE;
            end
            OP_PROP:
            begin
                push_cmd.kind = (in_range(evt.var_a, lim.nv) && in_range(evt.var_b, lim.nv))
                                ? K_PROP : K_IGNORE;
            end
            OP_CLEAR:
            begin
                push_cmd.kind = K_CLEAR;
            end
            OP_READ:
            begin
                push_cmd.kind = in_range(evt.label, lim.nc) ? K_READ : K_NOP;
            end
            default:
            begin
                push_cmd.kind = K_NOP;
            end
        endcase
    end

endmodule

### hdl/clm_back.sv
// back end: label and histogram memories, counters and result register
module clm_back #(
    parameter int MAX_VARS        = 4096,
    parameter int MAX_COMMUNITIES = 4096,
    parameter int COUNT_BITS      = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  clm_pkg::limits_t      lim,
    input  logic                  q_valid,
    input  clm_pkg::cmd_t         q_cmd,
    output logic                  q_pop,
    output clm_pkg::back_status_t status,
    output logic                  res_valid,
    input  logic                  res_ready,
    output clm_pkg::res_t         res
);
    import clm_pkg::*;

    localparam int VAR_AW  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int COMM_AW = (MAX_COMMUNITIES > 1) ? $clog2(MAX_COMMUNITIES) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COMM_AW-1:0]    LAST_COMM = COMM_AW'(MAX_COMMUNITIES - 1);

    function automatic logic [VAR_AW-1:0] var_addr(input logic [VAR_W-1:0] v);
        logic [VAR_AW+VAR_W-1:0] wide;
        wide = {{VAR_AW{1'b0}}, v};
        return wide[VAR_AW-1:0];
    endfunction

    function automatic logic [COMM_AW-1:0] comm_addr(input logic [LABEL_W-1:0] v);
        logic [COMM_AW+LABEL_W-1:0] wide;
        wide = {{COMM_AW{1'b0}}, v};
        return wide[COMM_AW-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS+OUT_W-1:0] wide;
        wide = {{OUT_W{1'b0}}, v};
        return wide[OUT_W-1:0];
    endfunction

    back_state_t state_reg, state_next;
    cmd_t        cur_reg, cur_next;
    logic [LABEL_W-1:0]    lab_a_reg, lab_a_next;
    logic [COMM_AW-1:0]    sweep_idx_reg, sweep_idx_next;
    logic [COUNT_BITS-1:0] dec_total_reg, dec_total_next;
    logic [COUNT_BITS-1:0] dec_same_reg, dec_same_next;
    logic [COUNT_BITS-1:0] dec_cross_reg, dec_cross_next;
    logic [COUNT_BITS-1:0] prop_total_reg, prop_total_next;
    logic [COUNT_BITS-1:0] prop_same_reg, prop_same_next;
    logic [COUNT_BITS-1:0] prop_cross_reg, prop_cross_next;
    logic [VAR_W-1:0]      last_var_reg, last_var_next;
    logic                  last_valid_reg, last_valid_next;
    logic                  ignored_reg, ignored_next;
    logic [COUNT_BITS-1:0] ccount_reg, ccount_next;
    logic                  res_valid_reg, res_valid_next;
    res_t                  res_reg, res_next;
    logic                  out_load;

    logic                  lab_we;
    logic [VAR_AW-1:0]     lab_waddr, lab_raddr;
    logic [LABEL_W-1:0]    lab_wdata, lab_rdata;
    logic                  hist_we;
    logic [COMM_AW-1:0]    hist_waddr, hist_raddr;
    logic [COUNT_BITS-1:0] hist_wdata, hist_rdata;

    clm_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (MAX_VARS)
    ) u_label_ram (
        .clk   (clk),
        .we    (lab_we),
        .waddr (lab_waddr),
        .wdata (lab_wdata),
        .raddr (lab_raddr),
        .rdata (lab_rdata)
    );

    clm_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_COMMUNITIES)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        lab_a_next      = lab_a_reg;
        sweep_idx_next  = sweep_idx_reg;
        dec_total_next  = dec_total_reg;
        dec_same_next   = dec_same_reg;
        dec_cross_next  = dec_cross_reg;
        prop_total_next = prop_total_reg;
        prop_same_next  = prop_same_reg;
        prop_cross_next = prop_cross_reg;
        last_var_next   = last_var_reg;
        last_valid_next = last_valid_reg;
        ignored_next    = ignored_reg;
        ccount_next     = ccount_reg;
        q_pop           = 1'b0;
        out_load        = 1'b0;
        lab_we          = 1'b0;
        lab_waddr       = var_addr(cur_reg.var_a);
        lab_wdata       = cur_reg.label;
        lab_raddr       = var_addr(cur_reg.var_a);
        hist_we         = 1'b0;
        hist_waddr      = comm_addr(lab_a_reg);
        hist_wdata      = sat_inc(hist_rdata);
        hist_raddr      = comm_addr(lab_a_reg);

        unique case (state_reg)
            ST_SWEEP:
            begin
                hist_we        = 1'b1;
                hist_waddr     = sweep_idx_reg;
                hist_wdata     = '0;
                sweep_idx_next = sweep_idx_reg + COMM_AW'(1);
                if (sweep_idx_reg == LAST_COMM)
                begin
                    sweep_idx_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_cmd;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                ignored_next = 1'b0;
                ccount_next  = '0;
                state_next   = ST_FINISH;
                unique case (cur_reg.kind)
                    K_LOAD:
                    begin
                        lab_we = 1'b1;
                    end
                    K_IGNORE:
                    begin
                        ignored_next = 1'b1;
                    end
                    K_CLEAR:
                    begin
                        dec_total_next  = '0;
                        dec_same_next   = '0;
                        dec_cross_next  = '0;
                        prop_total_next = '0;
                        prop_same_next  = '0;
                        prop_cross_next = '0;
                        last_var_next   = '0;
                        last_valid_next = 1'b0;
                    end
                    K_READ:
                    begin
                        hist_raddr = comm_addr(cur_reg.label);
                        state_next = ST_HIST;
                    end
                    K_DECIDE, K_PROP:
                    begin
                        state_next = ST_LABEL_A;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_LABEL_A:
            begin
                // first label is back; fetch the one it is compared with
                lab_a_next = lab_rdata;
                lab_raddr  = (cur_reg.kind == K_DECIDE) ? var_addr(last_var_reg)
                                                        : var_addr(cur_reg.var_b);
                state_next = ST_LABEL_B;
            end
            ST_LABEL_B:
            begin
                state_next = ST_FINISH;
                if (cur_reg.kind == K_DECIDE)
                begin
                    dec_total_next = sat_inc(dec_total_reg);
                    if (last_valid_reg && in_range(last_var_reg, lim.nv))
                    begin
                        if (lab_rdata == lab_a_reg)
                        begin
                            dec_same_next = sat_inc(dec_same_reg);
                        end
                        else
                        begin
                            dec_cross_next = sat_inc(dec_cross_reg);
                        end
                    end
                    last_var_next   = cur_reg.var_a;
                    last_valid_next = 1'b1;
                    if (in_range(lab_a_reg, lim.nc))
                    begin
                        state_next = ST_HIST;
                    end
                end
                else
                begin
                    prop_total_next = sat_inc(prop_total_reg);
                    if (lab_rdata == lab_a_reg)
                    begin
                        prop_same_next = sat_inc(prop_same_reg);
                    end
                    else
                    begin
                        prop_cross_next = sat_inc(prop_cross_reg);
                    end
                end
            end
            ST_HIST:
            begin
                state_next = ST_FINISH;
                if (cur_reg.kind == K_DECIDE)
                begin
                    hist_we     = 1'b1;
                    ccount_next = sat_inc(hist_rdata);
                end
                else
                begin
                    ccount_next = hist_rdata;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    out_load   = 1'b1;
                    state_next = (cur_reg.kind == K_CLEAR) ? ST_SWEEP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_next                    = res_reg;
        res_valid_next              = res_valid_reg;
        if (out_load)
        begin
            res_valid_next              = 1'b1;
            res_next.ignored            = ignored_reg;
            res_next.all_decisions      = to_out(dec_total_reg);
            res_next.same_decisions     = to_out(dec_same_reg);
            res_next.cross_decisions    = to_out(dec_cross_reg);
            res_next.total_propagations = to_out(prop_total_reg);
            res_next.same_propagations  = to_out(prop_same_reg);
            res_next.cross_propagations = to_out(prop_cross_reg);
            res_next.community_count    = to_out(ccount_reg);
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_idx_reg  <= '0;
            dec_total_reg  <= '0;
            dec_same_reg   <= '0;
            dec_cross_reg  <= '0;
            prop_total_reg <= '0;
            prop_same_reg  <= '0;
            prop_cross_reg <= '0;
            last_var_reg   <= '0;
            last_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_idx_reg  <= sweep_idx_next;
            dec_total_reg  <= dec_total_next;
            dec_same_reg   <= dec_same_next;
            dec_cross_reg  <= dec_cross_next;
            prop_total_reg <= prop_total_next;
            prop_same_reg  <= prop_same_next;
            prop_cross_reg <= prop_cross_next;
            last_var_reg   <= last_var_next;
            last_valid_reg <= last_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        lab_a_reg   <= lab_a_next;
        ignored_reg <= ignored_next;
        ccount_reg  <= ccount_next;
        res_reg     <= res_next;
    end

    assign status.sweeping = (state_reg == ST_SWEEP);
    assign res_valid       = res_valid_reg;
    assign res             = res_reg;

endmodule

### hdl/community_locality_monitor.sv
// top level of the community locality monitor
//
//   port group   dir   width          meaning
//   evt_*        in    evt_t (39)     event word: op, var_a, var_b, label
//   res_*        out   res_t (225)    result word: ignored flag, counters, community count
//   cfg_*        in    2 + 13         register write: variable count, community count
//
// every event word gives exactly one result word, in order
// back end: loads, ignored and unused ops go straight to the result, a histogram
// read adds a histogram lookup, a propagation reads two labels, and a decision
// reads two labels (one label ram read port), then the histogram if in range
// reset stats adds a sweep over the histogram ram; after reset it runs with evt_ready low
// a two-word queue keeps evt_ready high, until it fills, while results wait on res_ready
module community_locality_monitor #(
    parameter int MAX_VARS        = 4096,
    parameter int MAX_COMMUNITIES = 4096,
    parameter int COUNT_BITS      = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             evt_valid,
    output logic                             evt_ready,
    input  clm_pkg::evt_t                    evt,
    output logic                             res_valid,
    input  logic                             res_ready,
    output clm_pkg::res_t                    res,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [clm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clm_pkg::CFG_W-1:0]        cfg_data
);
    import clm_pkg::*;

    localparam int MV_W = $clog2(MAX_VARS + 1);
    localparam int MC_W = $clog2(MAX_COMMUNITIES + 1);

    logic [CFG_W-1:0] nvars_reg, nvars_next;
    logic [CFG_W-1:0] num_comms_reg, num_comms_next;
    limits_t          lim;
    back_status_t     status;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic             push;
    cmd_t             push_cmd;
    cmd_t             q_cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        nvars_next     = nvars_reg;
        num_comms_next = num_comms_reg;
        if (cfg_valid)
        begin
            if (cfg_index == CFG_NUM_VARS)
            begin
                nvars_next = cfg_data;
            end
            else if (cfg_index == CFG_NUM_COMMS)
            begin
                num_comms_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nvars_reg     <= '0;
            num_comms_reg <= '0;
        end
        else
        begin
            nvars_reg     <= nvars_next;
            num_comms_reg <= num_comms_next;
        end
    end

    // clamp programmed counts to the table sizes
    assign lim.nv = ({{MV_W{1'b0}}, nvars_reg} > {{CFG_W{1'b0}}, MV_W'(MAX_VARS)})
                    ? CFG_W'(MAX_VARS) : nvars_reg;
    assign lim.nc = ({{MC_W{1'b0}}, num_comms_reg} > {{CFG_W{1'b0}}, MC_W'(MAX_COMMUNITIES)})
                    ? CFG_W'(MAX_COMMUNITIES) : num_comms_reg;

    clm_front #(
        .MAX_VARS (MAX_VARS)
    ) u_front (
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .lim       (lim),
        .status    (status),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    clm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_cmd)
    );

    clm_back #(
        .MAX_VARS        (MAX_VARS),
        .MAX_COMMUNITIES (MAX_COMMUNITIES),
        .COUNT_BITS      (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .lim       (lim),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .status    (status),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

### hdl/clm_checker.sv
// port-level assertions for the locality monitor and their bind
module clm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          res_valid,
    input logic          res_ready,
    input clm_pkg::res_t res,
    input logic          cfg_valid,
    input logic          cfg_ready
);

    // a stalled result word stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    // and does not change under stall
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res))
        else $error("result word changed while stalled");

    // an ignored event never reports a histogram count
    a_ignored_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.ignored |-> res.community_count == '0)
        else $error("ignored event carries a community count");

    // register writes are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind community_locality_monitor clm_checker u_clm_checker (.*);

### sim/locality_checker.sv
// locality checker: predicts each result word from the event and register channels and compares
`timescale 1ns / 100ps

module locality_checker #(
    parameter int MAX_VARS        = 4096,
    parameter int MAX_COMMUNITIES = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             evt_valid,
    input  logic                             evt_ready,
    input  clm_pkg::evt_t                    evt,
    input  logic                             res_valid,
    input  logic                             res_ready,
    input  clm_pkg::res_t                    res,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [clm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clm_pkg::CFG_W-1:0]        cfg_data,
    output int                               mismatches,
    output int                               awaiting,
    output int                               checked
);
    import clm_pkg::*;

    logic [LABEL_W-1:0] comm_of [MAX_VARS];
    logic [OUT_W-1:0]   hist [MAX_COMMUNITIES];
    logic [CFG_W-1:0]   lim_vars;
    logic [CFG_W-1:0]   lim_comms;
    logic [OUT_W-1:0]   n_dec, n_dec_same, n_dec_cross;
    logic [OUT_W-1:0]   n_prop, n_prop_same, n_prop_cross;
    logic [VAR_W-1:0]   prev_var;
    logic               prev_seen;
    res_t               stats_due [$];
    res_t               want;
    res_t               got;
    int                 fail_tally;
    int                 match_tally;

    function automatic logic [OUT_W-1:0] sat_bump(input logic [OUT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic logic [CFG_W-1:0] clamp_limit(input logic [CFG_W-1:0] v, input int ceil);
        return (v > ceil) ? CFG_W'(ceil) : v;
    endfunction

    task automatic clear_counts();
        n_dec        = '0;
        n_dec_same   = '0;
        n_dec_cross  = '0;
        n_prop       = '0;
        n_prop_same  = '0;
        n_prop_cross = '0;
        prev_var     = '0;
        prev_seen    = 1'b0;
        for (int i = 0; i < MAX_COMMUNITIES; i++)
        begin
            hist[i] = '0;
        end
    endtask

    task automatic track_locality(input evt_t w, output res_t r);
        logic [LABEL_W-1:0] c;
        r = '0;
        case (w.op)
            OP_LOAD:
            begin
                if (w.var_a < MAX_VARS)
                    comm_of[w.var_a] = w.label;
                else
                    r.ignored = 1'b1;
            end
            OP_DECIDE:
            begin
                if (w.var_a >= lim_vars)
                begin
                    r.ignored = 1'b1;
                end
                else
                begin
                    c = comm_of[w.var_a];
                    n_dec = sat_bump(n_dec);
                    if (c < lim_comms)
                    begin
                        hist[c] = sat_bump(hist[c]);
                        r.community_count = hist[c];
                    end
                    // previous decision only counts while its variable is still in range
                    if (prev_seen && prev_var < lim_vars)
                    begin
                        if (comm_of[prev_var] == c)
                            n_dec_same = sat_bump(n_dec_same);
                        else
                            n_dec_cross = sat_bump(n_dec_cross);
                    end
                    prev_var  = w.var_a;
                    prev_seen = 1'b1;
                end
            end
            OP_PROP:
            begin
                if (w.var_a >= lim_vars || w.var_b >= lim_vars)
                begin
                    r.ignored = 1'b1;
                end
                else
                begin
                    n_prop = sat_bump(n_prop);
                    if (comm_of[w.var_a] == comm_of[w.var_b])
                        n_prop_same = sat_bump(n_prop_same);
                    else
                        n_prop_cross = sat_bump(n_prop_cross);
                end
            end
            OP_CLEAR:
            begin
                clear_counts();
            end
            OP_READ:
            begin
                if (w.label < lim_comms)
                    r.community_count = hist[w.label];
            end
            default:
            begin
            end
        endcase
        r.all_decisions      = n_dec;
        r.same_decisions     = n_dec_same;
        r.cross_decisions    = n_dec_cross;
        r.total_propagations = n_prop;
        r.same_propagations  = n_prop_same;
        r.cross_propagations = n_prop_cross;
    endtask

    task automatic check_field(input string name, input logic [OUT_W-1:0] exp_v,
                               input logic [OUT_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_vars  = '0;
            lim_comms = '0;
            for (int i = 0; i < MAX_VARS; i++)
            begin
                comm_of[i] = '0;
            end
            clear_counts();
            stats_due.delete();
            fail_tally  = 0;
            match_tally = 0;
            mismatches <= 0;
            awaiting   <= 0;
            checked    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_NUM_VARS)
                    lim_vars = clamp_limit(cfg_data, MAX_VARS);
                else if (cfg_index == CFG_NUM_COMMS)
                    lim_comms = clamp_limit(cfg_data, MAX_COMMUNITIES);
            end
            if (evt_valid && evt_ready)
            begin
                track_locality(evt, want);
                stats_due.insert(stats_due.size(), want);
            end
            if (res_valid && res_ready)
            begin
                got = res;
                if (stats_due.size() == 0)
                begin
                    $error("result word with no event outstanding");
                    fail_tally++;
                end
                else
                begin
                    want = stats_due.pop_front();
                    check_field("ignored", OUT_W'(want.ignored), OUT_W'(got.ignored));
                    check_field("all_decisions", want.all_decisions, got.all_decisions);
                    check_field("same_decisions", want.same_decisions, got.same_decisions);
                    check_field("cross_decisions", want.cross_decisions, got.cross_decisions);
                    check_field("total_propagations", want.total_propagations,
                                got.total_propagations);
                    check_field("same_propagations", want.same_propagations,
                                got.same_propagations);
                    check_field("cross_propagations", want.cross_propagations,
                                got.cross_propagations);
                    check_field("community_count", want.community_count, got.community_count);
                    match_tally++;
                end
            end
            mismatches <= fail_tally;
            awaiting   <= stats_due.size();
            checked    <= match_tally;
        end
    end

endmodule

### sim/testbench.sv
// top of the locality monitor testbench: stimulus, idling and verdict
`timescale 1ns / 100ps

module testbench;
    import clm_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int VAR_TOP     = (1 << VAR_W) - 1;
    localparam int LABEL_TOP   = (1 << LABEL_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int N_PHASES = 8;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 evt_valid = 1'b0;
    logic                 evt_ready;
    evt_t                 evt = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    res_t                 res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int mismatches;
    int awaiting;
    int checked;

    int cycle_count = 0;
    int feed_idle = 0;
    int drain_idle = 0;
    int cur_vars = 0;
    int cur_comms = 0;
    int words_sent = 0;
    int clears_sent = 0;
    int settings_used = 0;

    bit loaded [1 << VAR_W];
    int known_q [$];

    community_locality_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    locality_checker watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt        (evt),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaiting   (awaiting),
        .checked    (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(99) >= drain_idle);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("community_locality_monitor verification failed");
            $finish;
        end
    end

    function automatic evt_t make_evt(input logic [OP_W-1:0] op, input int a, input int b,
                                      input int lab);
        evt_t w;
        w.op    = op;
        w.var_a = VAR_W'(a);
        w.var_b = VAR_W'(b);
        w.label = LABEL_W'(lab);
        return w;
    endfunction

    task automatic push_event(input evt_t w);
        if ($urandom_range(99) < feed_idle)
        begin
            evt_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < feed_idle)
                @(posedge clk);
        end
        evt_valid <= 1'b1;
        evt       <= w;
        @(posedge clk);
        while (!evt_ready)
            @(posedge clk);
        words_sent++;
        if (w.op == OP_CLEAR)
            clears_sent++;
        if (w.op == OP_LOAD && !loaded[w.var_a])
        begin
            loaded[w.var_a] = 1'b1;
            known_q.insert(known_q.size(), int'(w.var_a));
        end
    endtask

    // drop valid and hold off until every result word is back and the block takes events
    task automatic settle();
        evt_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaiting != 0);
        while (!evt_ready)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(input int nv, input int nc);
        settle();
        write_reg(CFG_NUM_VARS, CFG_W'(nv));
        write_reg(CFG_NUM_COMMS, CFG_W'(nc));
        cur_vars  = (nv > (1 << VAR_W)) ? (1 << VAR_W) : nv;
        cur_comms = (nc > (1 << LABEL_W)) ? (1 << LABEL_W) : nc;
        settings_used++;
    endtask

    // a labelled variable that is below the current variable count
    function automatic bit pick_known(output int v);
        int fit [$];
        v = 0;
        foreach (known_q[i])
        begin
            if (known_q[i] < cur_vars)
                fit.insert(fit.size(), known_q[i]);
        end
        if (fit.size() == 0)
            return 1'b0;
        v = fit[$urandom_range(fit.size() - 1)];
        return 1'b1;
    endfunction

    // mostly near the community count so hits, misses and both compare results occur
    function automatic int pick_label();
        int hi;
        hi = (cur_comms + 1 > LABEL_TOP) ? LABEL_TOP : cur_comms + 1;
        if ($urandom_range(3) == 0)
            return $urandom_range(LABEL_TOP);
        return $urandom_range(hi);
    endfunction

    task automatic random_event();
        int r;
        int a;
        int b;
        int span;
        r = $urandom_range(99);
        if (r >= 18 && r < 78 && !pick_known(a))
            r = 0;
        if (r < 18)
        begin
            span = (cur_vars < 48) ? cur_vars : 48;
            if (span != 0 && $urandom_range(9) < 7)
                a = $urandom_range(span - 1);
            else
                a = $urandom_range(VAR_TOP);
            push_event(make_evt(OP_LOAD, a, $urandom_range(VAR_TOP), pick_label()));
        end
        else if (r < 53)
        begin
            push_event(make_evt(OP_DECIDE, a, $urandom_range(VAR_TOP),
                                $urandom_range(LABEL_TOP)));
        end
        else if (r < 78)
        begin
            void'(pick_known(b));
            push_event(make_evt(OP_PROP, a, b, $urandom_range(LABEL_TOP)));
        end
        else if (r < 88)
        begin
            push_event(make_evt(OP_READ, $urandom_range(VAR_TOP), $urandom_range(VAR_TOP),
                                pick_label()));
        end
        else if (r == 88)
        begin
            push_event(make_evt(OP_CLEAR, $urandom_range(VAR_TOP), $urandom_range(VAR_TOP),
                                $urandom_range(LABEL_TOP)));
        end
        else if (r < 94)
        begin
            push_event(make_evt(OP_W'($urandom_range(7, 5)), $urandom_range(VAR_TOP),
                                $urandom_range(VAR_TOP), $urandom_range(LABEL_TOP)));
        end
        else if (cur_vars <= VAR_TOP)
        begin
            // out of range variable on a decision or on either side of a propagation
            a = $urandom_range(VAR_TOP, cur_vars);
            if (!pick_known(b))
                b = $urandom_range(VAR_TOP, cur_vars);
            case ($urandom_range(2))
                0: push_event(make_evt(OP_DECIDE, a, b, $urandom_range(LABEL_TOP)));
                1: push_event(make_evt(OP_PROP, a, b, $urandom_range(LABEL_TOP)));
                default: push_event(make_evt(OP_PROP, b, a, $urandom_range(LABEL_TOP)));
            endcase
        end
        else
        begin
            push_event(make_evt(OP_READ, 0, 0, pick_label()));
        end
    endtask

    initial
    begin
        int nv_set [N_PHASES];
        int nc_set [N_PHASES];
        int n_items [N_PHASES];

        nv_set  = '{64, 4096, 0, 8191, 1, 200, 32, 4096};
        nc_set  = '{8, 4096, 0, 8191, 1, 5000, 3, 64};
        n_items = '{150, 150, 40, 160, 100, 160, 230, 230};

        feed_idle  = 36;
        drain_idle = 79;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        set_limits(8, 4);
        write_reg(CFG_SPARE, '1);

        // directed: labels, then each decision, propagation and read case
        push_event(make_evt(OP_READ, 0, 0, 0));
        push_event(make_evt(OP_LOAD, 0, 0, 1));
        push_event(make_evt(OP_LOAD, 1, 0, 1));
        push_event(make_evt(OP_LOAD, 2, 0, 3));
        push_event(make_evt(OP_LOAD, 3, VAR_TOP, LABEL_TOP));
        push_event(make_evt(OP_LOAD, VAR_TOP, 0, 2));
        push_event(make_evt(OP_LOAD, 7, 0, 0));
        push_event(make_evt(OP_DECIDE, 0, 0, 0));
        push_event(make_evt(OP_DECIDE, 1, 0, 0));
        push_event(make_evt(OP_DECIDE, 2, 0, 0));
        push_event(make_evt(OP_DECIDE, 3, 0, 0));
        push_event(make_evt(OP_DECIDE, VAR_TOP, 0, 0));
        push_event(make_evt(OP_DECIDE, 8, 0, 0));
        push_event(make_evt(OP_PROP, 0, 1, 0));
        push_event(make_evt(OP_PROP, 2, 0, 0));
        push_event(make_evt(OP_PROP, 0, VAR_TOP, 0));
        push_event(make_evt(OP_PROP, VAR_TOP, 1, 0));
        push_event(make_evt(OP_READ, 0, 0, 1));
        push_event(make_evt(OP_READ, 0, 0, 4));
        push_event(make_evt(OP_READ, VAR_TOP, VAR_TOP, LABEL_TOP));
        push_event(make_evt(OP_W'(5), VAR_TOP, VAR_TOP, LABEL_TOP));
        push_event(make_evt(OP_W'(7), VAR_TOP, VAR_TOP, LABEL_TOP));
        push_event(make_evt(OP_W'(6), 0, 0, 0));
        push_event(make_evt(OP_CLEAR, 0, 0, 0));
        push_event(make_evt(OP_READ, 0, 0, 1));
        push_event(make_evt(OP_DECIDE, 1, 0, 0));
        push_event(make_evt(OP_DECIDE, 7, 0, 0));
        // shrinking the variable count leaves the last decided variable out of range
        set_limits(4, 4);
        push_event(make_evt(OP_DECIDE, 0, 0, 0));

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p == 3)
            begin
                feed_idle  = 79;
                drain_idle = 36;
            end
            else if (p == 6)
            begin
                feed_idle  = 0;
                drain_idle = 0;
            end
            set_limits(nv_set[p], nc_set[p]);
            repeat (n_items[p]) random_event();
        end

        settle();
        $display("sent %0d event words with %0d stat clears over %0d register settings",
                 words_sent, clears_sent, settings_used);
        $display("%0d result words compared, %0d variables labelled", checked, known_q.size());
        if (mismatches == 0)
            $display("community_locality_monitor verification clean");
        else
            $display("community_locality_monitor verification failed");
        $finish;
    end

endmodule
